### rtl/rbpc_pkg.sv
// rbpc_pkg: shared types, codes and constants of the ring buffer pointer control.
// No dependencies; used by rbpc_ctrl, rbpc_dp and the top level.
`timescale 1ns / 1ps

package rbpc_pkg;

  // field widths
  localparam int unsigned SizeW   = 24;
  localparam int unsigned OffW    = 23;
  localparam int unsigned LenW    = 16;
  localparam int unsigned FuncW   = 2;
  localparam int unsigned StatusW = 2;

  // ring size limits and fixed drain chunk
  localparam logic [SizeW-1:0] SizeMin   = 24'd16384;
  localparam logic [SizeW-1:0] SizeMax   = 24'd8388608;
  localparam logic [SizeW-1:0] SizeReset = 24'd5242880;
  localparam logic [LenW-1:0]  ChunkBytes = 16'd9400;

  // request codes
  typedef enum logic [FuncW-1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_DRAIN = 2'd1,
    FUNC_QUERY = 2'd2
  } func_e;

  // result codes
  typedef enum logic [StatusW-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_SHORT     = 2'd2,
    STATUS_SINK_BUSY = 2'd3
  } status_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;     // capture the input item
    logic calc;     // register fill and used levels
    logic commit;   // decide, move offsets, register transfer fields
    logic finish;   // register free and used levels after the step
  } dp_cmd_t;

endpackage

### rtl/rbpc_ctrl.sv
// rbpc_ctrl: sequencer of one item through capture, level calc, commit and finish.
// Depends on rbpc_pkg for the datapath command struct.
`timescale 1ns / 1ps

module rbpc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rbpc_pkg::dp_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CALC   = 3'd1;
  localparam logic [2:0] ST_COMMIT = 3'd2;
  localparam logic [2:0] ST_FINISH = 3'd3;
  localparam logic [2:0] ST_OUT    = 3'd4;

  logic [2:0] state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_CALC;
      ST_CALC:   state_d = ST_COMMIT;
      ST_COMMIT: state_d = ST_FINISH;
      ST_FINISH: state_d = ST_OUT;
      ST_OUT:    if (!out_stall_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // handshake and datapath commands
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.calc   = (state_q == ST_CALC);
    cmd_o.commit = (state_q == ST_COMMIT);
    cmd_o.finish = (state_q == ST_FINISH);
  end

  // at most one datapath step per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.calc, cmd_o.commit, cmd_o.finish}))
    else $error("rbpc_ctrl: overlapping datapath commands");

  // a result first shows in the cycle after the finish step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd_o.finish))
    else $error("rbpc_ctrl: result shown without finish step");

  // an accepted item always goes on to the level calc
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.calc && in_stall_o)
    else $error("rbpc_ctrl: accepted item not processed");

endmodule

### rtl/rbpc_dp.sv
// rbpc_dp: offsets, wrap flag, ring size register and result registers.
// Depends on rbpc_pkg for widths, constants and codes.
`timescale 1ns / 1ps

module rbpc_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rbpc_pkg::dp_cmd_t                cmd_i,
  input  logic                             cfg_we_i,
  input  logic [rbpc_pkg::SizeW-1:0]       cfg_wdata_i,
  input  logic [rbpc_pkg::FuncW-1:0]       func_i,
  input  logic [rbpc_pkg::LenW-1:0]        write_len_i,
  input  logic                             sink_ready_i,
  output logic [rbpc_pkg::StatusW-1:0]     status_o,
  output logic [rbpc_pkg::OffW-1:0]        start_offset_o,
  output logic [rbpc_pkg::LenW-1:0]        first_segment_o,
  output logic [rbpc_pkg::SizeW-1:0]       free_bytes_o,
  output logic [rbpc_pkg::SizeW-1:0]       used_bytes_o
);

  // state
  logic [rbpc_pkg::SizeW-1:0] size_q;
  logic [rbpc_pkg::OffW-1:0]  wr_q, wr_d;
  logic [rbpc_pkg::OffW-1:0]  rd_q, rd_d;
  logic                       flag_q, flag_d;

  // captured item
  logic [rbpc_pkg::FuncW-1:0] func_q;
  logic [rbpc_pkg::LenW-1:0]  len_q;
  logic                       ready_q;

  // levels and results
  logic [rbpc_pkg::SizeW-1:0] fill_q, used_q;
  rbpc_pkg::status_e          status_q, status_d;
  logic [rbpc_pkg::OffW-1:0]  start_q, start_d;
  logic [rbpc_pkg::LenW-1:0]  first_q, first_d;
  logic [rbpc_pkg::SizeW-1:0] free_out_q, used_out_q;

  // clamped config value
  logic [rbpc_pkg::SizeW-1:0] size_clamp;
  always_comb begin
    size_clamp = cfg_wdata_i;
    if (cfg_wdata_i < rbpc_pkg::SizeMin) size_clamp = rbpc_pkg::SizeMin;
    if (cfg_wdata_i > rbpc_pkg::SizeMax) size_clamp = rbpc_pkg::SizeMax;
  end

  // fill and free levels from the current offsets
  logic [rbpc_pkg::SizeW-1:0] fill_raw, fill_now, free_raw, free_now, used_now;
  always_comb begin
    fill_raw = {1'b0, wr_q} + size_q - {1'b0, rd_q};
    fill_now = (fill_raw >= size_q) ? (fill_raw - size_q) : fill_raw;
    free_raw = {1'b0, rd_q} + size_q - {1'b0, wr_q};
    if (rd_q == wr_q) begin
      free_now = flag_q ? '0 : size_q;
    end else begin
      free_now = (free_raw >= size_q) ? (free_raw - size_q) : free_raw;
    end
    used_now = size_q - free_now;
  end

  // write request: refuse at 2/3 full (3*fill + 2 >= 2*size) or if fill+len >= size
  logic [rbpc_pkg::SizeW+1:0] fill_x3, size_x2;
  logic [rbpc_pkg::SizeW:0]   fill_plus_len;
  logic                       wr_refuse;
  logic [rbpc_pkg::SizeW-1:0] wr_sum, wr_wrap, wr_tail;
  always_comb begin
    fill_x3       = {2'b00, fill_q} + {1'b0, fill_q, 1'b0} + 26'd2;
    size_x2       = {1'b0, size_q, 1'b0};
    fill_plus_len = {1'b0, fill_q} + {9'd0, len_q};
    wr_refuse     = (fill_x3 >= size_x2) || (fill_plus_len >= {1'b0, size_q});
    wr_sum        = {1'b0, wr_q} + {8'd0, len_q};
    wr_wrap       = (wr_sum >= size_q) ? (wr_sum - size_q) : wr_sum;
    wr_tail       = size_q - {1'b0, wr_q};
  end

  // drain request: fixed chunk from the read offset
  logic [rbpc_pkg::SizeW-1:0] rd_sum, rd_wrap, rd_tail;
  always_comb begin
    rd_sum  = {1'b0, rd_q} + {8'd0, rbpc_pkg::ChunkBytes};
    rd_wrap = (rd_sum >= size_q) ? (rd_sum - size_q) : rd_sum;
    rd_tail = size_q - {1'b0, rd_q};
  end

  // commit decision
  always_comb begin
    wr_d     = wr_q;
    rd_d     = rd_q;
    flag_d   = flag_q;
    status_d = rbpc_pkg::STATUS_OK;
    start_d  = '0;
    first_d  = '0;
    case (func_q)
      rbpc_pkg::FUNC_WRITE: begin
        if (wr_refuse) begin
          status_d = rbpc_pkg::STATUS_FULL;
        end else begin
          start_d = wr_q;
          first_d = (wr_sum <= size_q) ? len_q : wr_tail[rbpc_pkg::LenW-1:0];
          wr_d    = wr_wrap[rbpc_pkg::OffW-1:0];
          flag_d  = (wr_wrap[rbpc_pkg::OffW-1:0] == rd_q);
        end
      end
      rbpc_pkg::FUNC_DRAIN: begin
        if (used_q < {8'd0, rbpc_pkg::ChunkBytes}) begin
          status_d = rbpc_pkg::STATUS_SHORT;
        end else if (!ready_q) begin
          status_d = rbpc_pkg::STATUS_SINK_BUSY;
        end else begin
          start_d = rd_q;
          first_d = (rd_sum <= size_q) ? rbpc_pkg::ChunkBytes
                                       : rd_tail[rbpc_pkg::LenW-1:0];
          rd_d    = rd_wrap[rbpc_pkg::OffW-1:0];
        end
      end
      default: begin
        // query and unused code: no change
      end
    endcase
  end

  // control state: size, offsets, flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= rbpc_pkg::SizeReset;
      wr_q   <= '0;
      rd_q   <= '0;
      flag_q <= 1'b0;
    end else if (cfg_we_i) begin
      size_q <= size_clamp;
      wr_q   <= '0;
      rd_q   <= '0;
      flag_q <= 1'b0;
    end else if (cmd_i.commit) begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      flag_q <= flag_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      len_q   <= write_len_i;
      ready_q <= sink_ready_i;
    end
    if (cmd_i.calc) begin
      fill_q <= fill_now;
      used_q <= used_now;
    end
    if (cmd_i.commit) begin
      status_q <= status_d;
      start_q  <= start_d;
      first_q  <= first_d;
    end
    if (cmd_i.finish) begin
      free_out_q <= free_now;
      used_out_q <= used_now;
    end
  end

  assign status_o        = status_q;
  assign start_offset_o  = start_q;
  assign first_segment_o = first_q;
  assign free_bytes_o    = free_out_q;
  assign used_bytes_o    = used_out_q;

  // offsets stay inside the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, wr_q} < size_q) && ({1'b0, rd_q} < size_q))
    else $error("rbpc_dp: offset beyond ring size");

  // ring size stays in its legal range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (size_q >= rbpc_pkg::SizeMin) && (size_q <= rbpc_pkg::SizeMax))
    else $error("rbpc_dp: ring size out of range");

  // a drain never touches the write side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && !cfg_we_i && (func_q == rbpc_pkg::FUNC_DRAIN) |=>
      $stable(wr_q) && (flag_q == $past(flag_q)))
    else $error("rbpc_dp: drain moved write offset or flag");

endmodule

### rtl/ring_buffer_pointer_control_core.sv
// ring_buffer_pointer_control_core: top level of the ring buffer pointer control.
// Depends on rbpc_pkg, rbpc_ctrl and rbpc_dp.
//
//   channel   handshake                  payload
//   input     in_valid_i / in_stall_o    func_i, write_len_i, sink_ready_i
//   output    out_valid_o / out_stall_i  status_o, start_offset_o, first_segment_o,
//                                        free_bytes_o, used_bytes_o
//   config    cfg_we_i                   cfg_wdata_i (ring size, clamped)
//
// each item passes the capture, level calc, commit and finish steps of the sequencer
// before its result is valid; a new item may enter only once the result is taken,
// so the block holds one item at a time.
// reset sets the ring size to 5242880 and clears both offsets and the wrap flag.
// a stalled result holds on the output registers; the input stays stalled meanwhile.
// a config write clears offsets and flag along with the new size.
`timescale 1ns / 1ps

module ring_buffer_pointer_control_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rbpc_pkg::SizeW-1:0]       cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [rbpc_pkg::FuncW-1:0]       func_i,
  input  logic [rbpc_pkg::LenW-1:0]        write_len_i,
  input  logic                             sink_ready_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [rbpc_pkg::StatusW-1:0]     status_o,
  output logic [rbpc_pkg::OffW-1:0]        start_offset_o,
  output logic [rbpc_pkg::LenW-1:0]        first_segment_o,
  output logic [rbpc_pkg::SizeW-1:0]       free_bytes_o,
  output logic [rbpc_pkg::SizeW-1:0]       used_bytes_o
);

  rbpc_pkg::dp_cmd_t cmd;

  // sequencer
  rbpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // pointer datapath
  rbpc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .func_i          (func_i),
    .write_len_i     (write_len_i),
    .sink_ready_i    (sink_ready_i),
    .status_o        (status_o),
    .start_offset_o  (start_offset_o),
    .first_segment_o (first_segment_o),
    .free_bytes_o    (free_bytes_o),
    .used_bytes_o    (used_bytes_o)
  );

endmodule

### dv/ring_buffer_pointer_control_core_tb.sv
// ring_buffer_pointer_control_core_tb: self-checking bench for the ring buffer pointer control.
// Depends on rbpc_pkg and ring_buffer_pointer_control_core; predicts untyped results in place.
// Directed rows first, then random phases over several ring sizes and idle/stall patterns.
`timescale 1ns / 1ps

module ring_buffer_pointer_control_core_tb;
  import rbpc_pkg::*;

  // request code the block treats as a query
  localparam logic [FuncW-1:0] FuncUnused = 2'd3;

  localparam int NumPhases     = 7;
  localparam int PhaseItems    = 200;
  localparam int PressurePhase = 4;
  localparam int HoldCycles    = 300;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 20;

  localparam int SendIdlePct  [NumPhases] = '{0, 77, 0, 6, 0, 77, 0};
  localparam int RecvStallPct [NumPhases] = '{0, 0, 77, 6, 0, 0, 77};

  // one result of the block
  typedef struct packed {
    status_e           status;
    logic [OffW-1:0]   start;
    logic [LenW-1:0]   first;
    logic [SizeW-1:0]  free;
    logic [SizeW-1:0]  used;
  } ring_result_t;

  localparam ring_result_t NoWant = '0;

  // directed stimulus row: either a ring size write or one item
  typedef struct packed {
    bit                is_cfg;
    logic [FuncW-1:0]  func;
    logic [LenW-1:0]   len;
    logic              ready;
    logic [SizeW-1:0]  cfg_value;
    bit                typed;
    ring_result_t      want;
  } dir_row_t;

  localparam int NumRows = 22;
  localparam dir_row_t DirectedRows [NumRows] = '{
    // reset state, empty ring
    '{1'b0, FUNC_QUERY, 16'd0, 1'b1, 24'd0, 1'b1,
      '{STATUS_OK, 23'd0, 16'd0, SizeReset, 24'd0}},
    '{1'b0, FUNC_DRAIN, 16'd0, 1'b1, 24'd0, 1'b1,
      '{STATUS_SHORT, 23'd0, 16'd0, SizeReset, 24'd0}},
    // unused selector behaves as query
    '{1'b0, FuncUnused, 16'hFFFF, 1'b1, 24'd0, 1'b1,
      '{STATUS_OK, 23'd0, 16'd0, SizeReset, 24'd0}},
    // zero-length write on empty ring sets the wrap flag: reads as full
    '{1'b0, FUNC_WRITE, 16'd0, 1'b0, 24'd0, 1'b1,
      '{STATUS_OK, 23'd0, 16'd0, 24'd0, SizeReset}},
    '{1'b0, FUNC_DRAIN, 16'd0, 1'b0, 24'd0, 1'b1,
      '{STATUS_SINK_BUSY, 23'd0, 16'd0, 24'd0, SizeReset}},
    // drain keeps the flag, then a write sees a high fill
    '{1'b0, FUNC_DRAIN, 16'd0, 1'b1, 24'd0, 1'b0, NoWant},
    '{1'b0, FUNC_WRITE, 16'hFFFF, 1'b1, 24'd0, 1'b0, NoWant},
    // size below range clamps to the minimum
    '{1'b1, FUNC_QUERY, 16'd0, 1'b0, 24'd0, 1'b0, NoWant},
    '{1'b0, FUNC_WRITE, 16'hFFFF, 1'b0, 24'd0, 1'b1,
      '{STATUS_FULL, 23'd0, 16'd0, SizeMin, 24'd0}},
    '{1'b0, FUNC_WRITE, 16'd10000, 1'b1, 24'd0, 1'b0, NoWant},
    '{1'b0, FUNC_WRITE, 16'd1000, 1'b1, 24'd0, 1'b0, NoWant},
    // fill past two thirds refuses even a short write
    '{1'b0, FUNC_WRITE, 16'd100, 1'b1, 24'd0, 1'b0, NoWant},
    '{1'b0, FUNC_DRAIN, 16'd0, 1'b1, 24'd0, 1'b0, NoWant},
    '{1'b0, FUNC_DRAIN, 16'd0, 1'b1, 24'd0, 1'b0, NoWant},
    // write and drain across the wrap point
    '{1'b0, FUNC_WRITE, 16'd10000, 1'b1, 24'd0, 1'b0, NoWant},
    '{1'b0, FUNC_DRAIN, 16'd0, 1'b1, 24'd0, 1'b0, NoWant},
    '{1'b0, FUNC_WRITE, 16'd0, 1'b1, 24'd0, 1'b0, NoWant},
    '{1'b0, FUNC_DRAIN, 16'd0, 1'b0, 24'd0, 1'b0, NoWant},
    // size above range clamps to the maximum
    '{1'b1, FUNC_QUERY, 16'd0, 1'b0, 24'hFFFFFF, 1'b0, NoWant},
    '{1'b0, FUNC_WRITE, 16'hFFFF, 1'b1, 24'd0, 1'b1,
      '{STATUS_OK, 23'd0, 16'hFFFF, SizeMax - 24'd65535, 24'd65535}},
    '{1'b0, FUNC_DRAIN, 16'd0, 1'b1, 24'd0, 1'b0, NoWant},
    '{1'b0, FUNC_QUERY, 16'd0, 1'b0, 24'd0, 1'b0, NoWant}
  };

  // block ports
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [SizeW-1:0]    cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [FuncW-1:0]    func_i = '0;
  logic [LenW-1:0]     write_len_i = '0;
  logic                sink_ready_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [StatusW-1:0]  status_o;
  logic [OffW-1:0]     start_offset_o;
  logic [LenW-1:0]     first_segment_o;
  logic [SizeW-1:0]    free_bytes_o;
  logic [SizeW-1:0]    used_bytes_o;

  // predicted ring state
  int unsigned ring_size = 32'(SizeReset);
  int unsigned wr_off = 0;
  int unsigned rd_off = 0;
  bit          wrap_flag = 1'b0;

  ring_result_t results_due[$];
  int           mismatches = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  bit           hold_req = 1'b0;
  bit           hold_seen = 1'b0;
  int           hold_left = 0;
  int           quiet_cycles = 0;

  ring_buffer_pointer_control_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .write_len_i     (write_len_i),
    .sink_ready_i    (sink_ready_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .start_offset_o  (start_offset_o),
    .first_segment_o (first_segment_o),
    .free_bytes_o    (free_bytes_o),
    .used_bytes_o    (used_bytes_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // free bytes, with the flag telling full from empty
  function automatic int unsigned free_now();
    if (rd_off == wr_off) return wrap_flag ? 0 : ring_size;
    return (rd_off + ring_size - wr_off) % ring_size;
  endfunction

  // apply one request to the predicted ring and return its result
  function automatic ring_result_t advance_ring(logic [FuncW-1:0] func, logic [LenW-1:0] len,
                                                logic ready);
    ring_result_t r;
    int unsigned  fill;
    int unsigned  nxt;
    int unsigned  fb;
    r = NoWant;
    r.status = STATUS_OK;
    case (func)
      FUNC_WRITE: begin
        fill = (wr_off + ring_size - rd_off) % ring_size;
        if (fill >= ring_size * 2 / 3 || fill + len >= ring_size) begin
          r.status = STATUS_FULL;
        end else begin
          nxt = wr_off + len;
          r.start = OffW'(wr_off);
          r.first = (nxt <= ring_size) ? len : LenW'(ring_size - wr_off);
          if (nxt >= ring_size) nxt -= ring_size;
          wr_off = nxt;
          wrap_flag = (wr_off == rd_off);
        end
      end
      FUNC_DRAIN: begin
        if (ring_size - free_now() < ChunkBytes) begin
          r.status = STATUS_SHORT;
        end else if (!ready) begin
          r.status = STATUS_SINK_BUSY;
        end else begin
          nxt = rd_off + ChunkBytes;
          r.start = OffW'(rd_off);
          r.first = (nxt <= ring_size) ? ChunkBytes : LenW'(ring_size - rd_off);
          if (nxt >= ring_size) nxt -= ring_size;
          rd_off = nxt;
        end
      end
      default: ;
    endcase
    fb = free_now();
    r.free = SizeW'(fb);
    r.used = SizeW'(ring_size - fb);
    return r;
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // offer one item after a random gap, record its result once taken
  task automatic send_item(logic [FuncW-1:0] func, logic [LenW-1:0] len, logic ready,
                           bit typed, ring_result_t want);
    ring_result_t due;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= func;
    write_len_i  <= len;
    sink_ready_i <= ready;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    due = advance_ring(func, len, ready);
    results_due.push_back(typed ? want : due);
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  // ring size write; the block clamps it and clears both offsets and the flag
  task automatic write_ring_size(logic [SizeW-1:0] value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    ring_size = 32'((value < SizeMin) ? SizeMin : ((value > SizeMax) ? SizeMax : value));
    wr_off    = 0;
    rd_off    = 0;
    wrap_flag = 1'b0;
  endtask

  // result check and receiver stall, with an optional long hold-off
  always @(posedge clk_i) begin : result_check
    ring_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (results_due.size() == 0) begin
        mismatches++;
        $display("%0t unexpected item: status %0d start %0d first %0d free %0d used %0d",
                 $time, status_o, start_offset_o, first_segment_o, free_bytes_o,
                 used_bytes_o);
      end else begin
        want = results_due.pop_front();
        compare_field("status", 32'(want.status), 32'(status_o));
        compare_field("start_offset", 32'(want.start), 32'(start_offset_o));
        compare_field("first_segment", 32'(want.first), 32'(first_segment_o));
        compare_field("free_bytes", 32'(want.free), 32'(free_bytes_o));
        compare_field("used_bytes", 32'(want.used), 32'(used_bytes_o));
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
    end
    out_stall_i <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t watchdog: no handshake for %0d cycles", $time, quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin
    dir_row_t          row;
    logic [SizeW-1:0]  size_pick;
    logic [FuncW-1:0]  func_pick;
    logic [LenW-1:0]   len_pick;
    logic              ready_pick;
    int unsigned       roll;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    for (int i = 0; i < NumRows; i++) begin
      row = DirectedRows[i];
      if (row.is_cfg) begin
        wait_quiet();
        write_ring_size(row.cfg_value);
      end else begin
        send_item(row.func, row.len, row.ready, row.typed, row.want);
      end
    end

    // random phases, each with its own ring size and idle pattern
    for (int p = 0; p < NumPhases; p++) begin
      wait_quiet();
      send_idle_pct = SendIdlePct[p];
      recv_stall_pct <= RecvStallPct[p];
      case (p)
        0:       size_pick = SizeMin;
        1:       size_pick = SizeMax;
        2:       size_pick = SizeW'($urandom_range(SizeMax, SizeMin));
        3:       size_pick = SizeW'($urandom_range(200000, SizeMin));
        4:       size_pick = SizeW'($urandom_range(24'hFFFFFF, SizeMax + 1));
        5:       size_pick = SizeW'($urandom_range(SizeMin - 1, 0));
        default: size_pick = SizeW'($urandom_range(40000, SizeMin));
      endcase
      write_ring_size(size_pick);
      if (p == PressurePhase) hold_req <= ~hold_req;
      repeat (PhaseItems) begin
        roll = $urandom_range(99);
        if (roll < 45)      func_pick = FUNC_WRITE;
        else if (roll < 85) func_pick = FUNC_DRAIN;
        else if (roll < 95) func_pick = FUNC_QUERY;
        else                func_pick = FuncUnused;
        case ($urandom_range(7))
          0:       len_pick = '0;
          1:       len_pick = 16'hFFFF;
          2, 3:    len_pick = LenW'($urandom);
          default: len_pick = LenW'($urandom_range(12000));
        endcase
        ready_pick = ($urandom_range(99) < 80);
        send_item(func_pick, len_pick, ready_pick, 1'b0, NoWant);
      end
    end

    wait_quiet();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/rbpc_pkg.sv
rtl/rbpc_ctrl.sv
rtl/rbpc_dp.sv
rtl/ring_buffer_pointer_control_core.sv
dv/ring_buffer_pointer_control_core_tb.sv
